FILE: rtl/dcbms_pkg.sv
package dcbms_pkg;

  localparam int MAX_BOARDS_DEF = 16;
  localparam int MAX_BATTS_DEF  = 16;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_REFRESH = 2'd1;
  localparam logic [1:0] OP_REPLY   = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  localparam logic [1:0] PK_ACK    = 2'd0;
  localparam logic [1:0] PK_RESULT = 2'd1;
  localparam logic [1:0] PK_OTHER  = 2'd2;

  localparam logic [1:0] SEND_NONE   = 2'd0;
  localparam logic [1:0] SEND_SET    = 2'd1;
  localparam logic [1:0] SEND_GET    = 2'd2;
  localparam logic [1:0] SEND_RESEND = 2'd3;

  localparam logic [1:0] STORE_NONE = 2'd0;
  localparam logic [1:0] STORE_VOLT = 2'd1;
  localparam logic [1:0] STORE_STAT = 2'd2;

  localparam logic [2:0] CFG_TIMEOUT     = 3'd0;
  localparam logic [2:0] CFG_MAX_RETRIES = 3'd1;
  localparam logic [2:0] CFG_REG_ADDR    = 3'd2;
  localparam logic [2:0] CFG_REG_CELLS   = 3'd3;
  localparam logic [2:0] CFG_REG_VOLT    = 3'd4;
  localparam logic [2:0] CFG_REG_STAT    = 3'd5;

  localparam logic [15:0] TIMEOUT_RST     = 16'd100;
  localparam logic [3:0]  MAX_RETRIES_RST = 4'd3;
  localparam logic [15:0] REG_ADDR_RST    = 16'd0;
  localparam logic [15:0] REG_CELLS_RST   = 16'd1;
  localparam logic [15:0] REG_VOLT_RST    = 16'd16;
  localparam logic [15:0] REG_STAT_RST    = 16'd48;

  localparam logic [7:0] DEST_BROADCAST = 8'hFF;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ADDR = 2'd1,
    MODE_VOLT = 2'd2,
    MODE_STAT = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [7:0]  dest_board;
    logic [15:0] var_index;
    logic [7:0]  set_value;
  } req_t;

  typedef struct packed {
    req_t        req;
    logic [1:0]  store_kind;
    logic [7:0]  store_index;
    logic [31:0] store_value;
    logic        fault;
    logic        busy_res;
    logic [4:0]  boards_found;
    logic        last;
  } res_t;

  typedef struct packed {
    logic push0;
    logic push1;
    res_t r0;
    res_t r1;
  } oq_wr_t;

  function automatic req_t mk_req(logic [1:0] kind, logic [7:0] dest,
                                  logic [15:0] var_idx, logic [7:0] val);
    req_t r;
    r.send_kind  = kind;
    r.dest_board = dest;
    r.var_index  = var_idx;
    r.set_value  = val;
    return r;
  endfunction

endpackage

FILE: rtl/dcbms_outq.sv
module dcbms_outq (
  input  logic              clk,
  input  logic              rst,
  input  dcbms_pkg::oq_wr_t wr,
  output logic              room,
  output logic              m_valid,
  input  logic              m_ready,
  output dcbms_pkg::res_t   m_data
);

  dcbms_pkg::res_t q [dcbms_pkg::OQ_DEPTH];
  logic [dcbms_pkg::OQ_AW:0]   count;
  logic [dcbms_pkg::OQ_AW:0]   base;
  logic                        pop;
  logic [dcbms_pkg::OQ_AW:0]   n_push;

  assign pop     = m_valid && m_ready;
  assign m_valid = (count != '0);
  assign m_data  = q[0];
  assign room    = (count <= (dcbms_pkg::OQ_AW+1)'(dcbms_pkg::OQ_DEPTH - 2));
  assign n_push  = (dcbms_pkg::OQ_AW+1)'(wr.push0) + (dcbms_pkg::OQ_AW+1)'(wr.push1);
  assign base    = count - (dcbms_pkg::OQ_AW+1)'(pop);

  // Entries move toward the head on a pop; new results land behind the last one kept.
  always_ff @(posedge clk) begin
    for (int i = 0; i < dcbms_pkg::OQ_DEPTH; i++) begin
      if (wr.push0 && base == (dcbms_pkg::OQ_AW+1)'(i)) begin
        q[(dcbms_pkg::OQ_AW)'(i)] <= wr.r0;
      end else if (wr.push1 && base + 1'b1 == (dcbms_pkg::OQ_AW+1)'(i)) begin
        q[(dcbms_pkg::OQ_AW)'(i)] <= wr.r1;
      end else if (pop && i < dcbms_pkg::OQ_DEPTH - 1) begin
        q[(dcbms_pkg::OQ_AW)'(i)] <= q[(dcbms_pkg::OQ_AW)'(i + 1)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + n_push - (dcbms_pkg::OQ_AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (dcbms_pkg::OQ_AW+1)'(dcbms_pkg::OQ_DEPTH))
    else $error("Result queue holds more entries than it has.");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    wr.push0 |-> count <= (dcbms_pkg::OQ_AW+1)'(dcbms_pkg::OQ_DEPTH - 2))
    else $error("Result written into a queue without room for two.");

endmodule

FILE: rtl/dcbms_core.sv
module dcbms_core #(
  parameter int MAX_BOARDS = dcbms_pkg::MAX_BOARDS_DEF,
  parameter int MAX_BATTS  = dcbms_pkg::MAX_BATTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  logic [1:0]        s_op,
  input  logic [1:0]        s_pk,
  input  logic [31:0]       s_pay,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              room,
  output dcbms_pkg::oq_wr_t wr
);

  localparam int BW = $clog2(MAX_BOARDS + 1);
  localparam int CW = $clog2(MAX_BATTS + 1);
  localparam int AW = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;

  logic [15:0] timeout_ticks;
  logic [3:0]  max_retries;
  logic [15:0] reg_board_address;
  logic [15:0] reg_cell_count;
  logic [15:0] reg_first_voltage;
  logic [15:0] reg_first_status;

  logic        in_vld;
  logic [1:0]  in_op;
  logic [1:0]  in_pk;
  logic [31:0] in_pay;
  logic        proc;

  dcbms_pkg::mode_t mode, mode_next;
  logic [3:0]  retry_count, retry_count_next;
  logic [BW-1:0] board_total, board_total_next;
  logic [BW-1:0] cur_board, cur_board_next;
  logic [CW-1:0] cur_cell, cur_cell_next;
  logic [7:0]  flat_position, flat_position_next;
  logic        timer_on, timer_on_next;
  logic [15:0] elapsed, elapsed_next;
  dcbms_pkg::req_t prev_request, prev_request_next;

  logic [CW-1:0] cells_mem [MAX_BOARDS];
  logic [MAX_BOARDS-1:0] cells_valid;
  logic [CW-1:0] rd_cells;
  logic          rd_ok;
  logic [AW-1:0] rd_addr;
  logic [BW-1:0] rd_diff;
  logic [BW-1:0] wr_diff;
  logic [AW-1:0] wr_idx;
  logic          wr_en;
  logic          clr;
  logic [CW-1:0] wr_val;
  logic [CW-1:0] cells_now;

  dcbms_pkg::res_t r0, r1;
  logic        two;
  logic        flt;
  logic        retry_ok;
  logic        advance;
  logic [BW-1:0] nb;
  logic [CW-1:0] nc;
  logic [15:0] first;
  logic [1:0]  skind;
  logic [7:0]  bt8;

  assign proc     = in_vld && room;
  assign s_ready  = !in_vld || proc;
  assign retry_ok = (retry_count < max_retries);
  assign cells_now = rd_ok ? rd_cells : '0;
  assign wr_diff  = board_total - 1'b1;
  assign wr_idx   = wr_diff[AW-1:0];
  assign rd_diff  = cur_board_next - 1'b1;
  assign rd_addr  = rd_diff[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks     <= dcbms_pkg::TIMEOUT_RST;
      max_retries       <= dcbms_pkg::MAX_RETRIES_RST;
      reg_board_address <= dcbms_pkg::REG_ADDR_RST;
      reg_cell_count    <= dcbms_pkg::REG_CELLS_RST;
      reg_first_voltage <= dcbms_pkg::REG_VOLT_RST;
      reg_first_status  <= dcbms_pkg::REG_STAT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        dcbms_pkg::CFG_TIMEOUT:     timeout_ticks     <= cfg_data;
        dcbms_pkg::CFG_MAX_RETRIES: max_retries       <= cfg_data[3:0];
        dcbms_pkg::CFG_REG_ADDR:    reg_board_address <= cfg_data;
        dcbms_pkg::CFG_REG_CELLS:   reg_cell_count    <= cfg_data;
        dcbms_pkg::CFG_REG_VOLT:    reg_first_voltage <= cfg_data;
        dcbms_pkg::CFG_REG_STAT:    reg_first_status  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_valid && s_ready) begin
      in_vld <= 1'b1;
    end else if (proc) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      in_op  <= s_op;
      in_pk  <= s_pk;
      in_pay <= s_pay;
    end
  end

  // Cell counts: one write port, one registered read that follows the board being polled.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells_mem[wr_idx] <= wr_val;
    end
    rd_cells <= cells_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      cells_valid <= '0;
    end else if (wr_en) begin
      cells_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= cells_valid[rd_addr] && (cur_board_next != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= dcbms_pkg::MODE_IDLE;
      retry_count   <= '0;
      board_total   <= '0;
      cur_board     <= '0;
      cur_cell      <= '0;
      flat_position <= '0;
      timer_on      <= 1'b0;
      elapsed       <= '0;
      prev_request  <= '0;
    end else begin
      mode          <= mode_next;
      retry_count   <= retry_count_next;
      board_total   <= board_total_next;
      cur_board     <= cur_board_next;
      cur_cell      <= cur_cell_next;
      flat_position <= flat_position_next;
      timer_on      <= timer_on_next;
      elapsed       <= elapsed_next;
      prev_request  <= prev_request_next;
    end
  end

  always_comb begin
    mode_next          = mode;
    retry_count_next   = retry_count;
    board_total_next   = board_total;
    cur_board_next     = cur_board;
    cur_cell_next      = cur_cell;
    flat_position_next = flat_position;
    timer_on_next      = timer_on;
    elapsed_next       = elapsed;
    prev_request_next  = prev_request;
    r0      = '0;
    r1      = '0;
    two     = 1'b0;
    flt     = 1'b0;
    clr     = 1'b0;
    wr_en   = 1'b0;
    wr_val  = '0;
    advance = 1'b0;
    nb      = cur_board;
    nc      = cur_cell;
    first   = (mode == dcbms_pkg::MODE_VOLT) ? reg_first_voltage : reg_first_status;
    skind   = (mode == dcbms_pkg::MODE_VOLT) ? dcbms_pkg::STORE_VOLT : dcbms_pkg::STORE_STAT;

    if (proc) begin
      case (in_op)
        dcbms_pkg::OP_RESTART: begin
          board_total_next = '0;
          clr = 1'b1;
          r0.req = dcbms_pkg::mk_req(dcbms_pkg::SEND_SET, dcbms_pkg::DEST_BROADCAST,
                                     reg_board_address, 8'd0);
          r1.req = dcbms_pkg::mk_req(dcbms_pkg::SEND_SET, 8'd0, reg_board_address, 8'd1);
          prev_request_next = r1.req;
          retry_count_next  = '0;
          mode_next         = dcbms_pkg::MODE_ADDR;
          timer_on_next     = 1'b1;
          elapsed_next      = '0;
          two               = 1'b1;
        end
        dcbms_pkg::OP_REFRESH: begin
          if (board_total != '0) begin
            cur_board_next     = BW'(1);
            cur_cell_next      = CW'(1);
            flat_position_next = '0;
            retry_count_next   = '0;
            mode_next          = dcbms_pkg::MODE_VOLT;
            r0.req = dcbms_pkg::mk_req(dcbms_pkg::SEND_GET, 8'd1, reg_first_voltage, 8'd0);
            prev_request_next  = r0.req;
            timer_on_next      = 1'b1;
            elapsed_next       = '0;
          end
        end
        dcbms_pkg::OP_REPLY: begin
          if (mode == dcbms_pkg::MODE_ADDR) begin
            if (in_pk == dcbms_pkg::PK_ACK) begin
              if (board_total < BW'(MAX_BOARDS)) begin
                board_total_next = board_total + 1'b1;
              end
              retry_count_next = '0;
              r0.req = dcbms_pkg::mk_req(dcbms_pkg::SEND_GET, 8'(board_total_next),
                                         reg_cell_count, 8'd0);
              prev_request_next = r0.req;
              timer_on_next     = 1'b1;
              elapsed_next      = '0;
            end else if (in_pk == dcbms_pkg::PK_RESULT && board_total != '0) begin
              wr_en  = 1'b1;
              wr_val = (in_pay[15:0] > 16'(MAX_BATTS)) ? CW'(MAX_BATTS) : in_pay[CW-1:0];
              if (board_total >= BW'(MAX_BOARDS)) begin
                mode_next     = dcbms_pkg::MODE_IDLE;
                timer_on_next = 1'b0;
                elapsed_next  = '0;
              end else begin
                retry_count_next = '0;
                r0.req = dcbms_pkg::mk_req(dcbms_pkg::SEND_SET, 8'd0, reg_board_address,
                                           8'(board_total) + 8'd1);
                prev_request_next = r0.req;
                timer_on_next     = 1'b1;
                elapsed_next      = '0;
              end
            end else if (!retry_ok) begin
              mode_next     = dcbms_pkg::MODE_IDLE;
              timer_on_next = 1'b0;
              elapsed_next  = '0;
              flt           = 1'b1;
            end else begin
              retry_count_next = retry_count + 1'b1;
              r0.req           = prev_request;
              r0.req.send_kind = dcbms_pkg::SEND_RESEND;
              timer_on_next    = 1'b1;
              elapsed_next     = '0;
            end
          end else if (mode == dcbms_pkg::MODE_VOLT || mode == dcbms_pkg::MODE_STAT) begin
            if (in_pk == dcbms_pkg::PK_RESULT) begin
              r0.store_kind      = skind;
              r0.store_index     = flat_position;
              r0.store_value     = in_pay;
              flat_position_next = flat_position + 8'd1;
              if (cur_cell >= cells_now) begin
                if (cur_board >= board_total) begin
                  if (mode == dcbms_pkg::MODE_VOLT) begin
                    cur_board_next     = BW'(1);
                    cur_cell_next      = CW'(1);
                    flat_position_next = '0;
                    retry_count_next   = '0;
                    mode_next          = dcbms_pkg::MODE_STAT;
                    r0.req = dcbms_pkg::mk_req(dcbms_pkg::SEND_GET, 8'd1,
                                               reg_first_status, 8'd0);
                    prev_request_next  = r0.req;
                    timer_on_next      = 1'b1;
                    elapsed_next       = '0;
                  end else begin
                    mode_next     = dcbms_pkg::MODE_IDLE;
                    timer_on_next = 1'b0;
                    elapsed_next  = '0;
                  end
                end else begin
                  nb      = cur_board + 1'b1;
                  nc      = CW'(1);
                  advance = 1'b1;
                end
              end else begin
                nb      = cur_board;
                nc      = cur_cell + 1'b1;
                advance = 1'b1;
              end
              if (advance) begin
                cur_board_next   = nb;
                cur_cell_next    = nc;
                retry_count_next = '0;
                r0.req = dcbms_pkg::mk_req(dcbms_pkg::SEND_GET, 8'(nb),
                                           first + 16'(nc) - 16'd1, 8'd0);
                prev_request_next = r0.req;
                timer_on_next     = 1'b1;
                elapsed_next      = '0;
              end
            end else if (!retry_ok) begin
              mode_next     = dcbms_pkg::MODE_IDLE;
              timer_on_next = 1'b0;
              elapsed_next  = '0;
              flt           = 1'b1;
            end else begin
              retry_count_next = retry_count + 1'b1;
              r0.req           = prev_request;
              r0.req.send_kind = dcbms_pkg::SEND_RESEND;
              timer_on_next    = 1'b1;
              elapsed_next     = '0;
            end
          end
        end
        dcbms_pkg::OP_TICK: begin
          if (timer_on) begin
            if (elapsed >= timeout_ticks) begin
              timer_on_next = 1'b0;
              elapsed_next  = '0;
              if (mode == dcbms_pkg::MODE_ADDR) begin
                if (!retry_ok) begin
                  mode_next = dcbms_pkg::MODE_IDLE;
                  flt       = (board_total == '0);
                end else begin
                  retry_count_next = retry_count + 1'b1;
                  timer_on_next    = 1'b1;
                  if (board_total == '0) begin
                    r0.req = dcbms_pkg::mk_req(dcbms_pkg::SEND_SET,
                                               dcbms_pkg::DEST_BROADCAST,
                                               reg_board_address, 8'd0);
                    r1.req = dcbms_pkg::mk_req(dcbms_pkg::SEND_SET, 8'd0,
                                               reg_board_address, 8'd1);
                    prev_request_next = r1.req;
                    two = 1'b1;
                  end else begin
                    r0.req           = prev_request;
                    r0.req.send_kind = dcbms_pkg::SEND_RESEND;
                  end
                end
              end else if (mode == dcbms_pkg::MODE_VOLT || mode == dcbms_pkg::MODE_STAT) begin
                if (!retry_ok) begin
                  mode_next = dcbms_pkg::MODE_IDLE;
                  flt       = 1'b1;
                end else begin
                  retry_count_next = retry_count + 1'b1;
                  r0.req           = prev_request;
                  r0.req.send_kind = dcbms_pkg::SEND_RESEND;
                  timer_on_next    = 1'b1;
                end
              end
            end else begin
              elapsed_next = elapsed + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    bt8 = 8'(board_total_next);
    wr.push0 = proc;
    wr.push1 = proc && two;
    wr.r0 = r0;
    wr.r0.busy_res     = (mode_next != dcbms_pkg::MODE_IDLE);
    wr.r0.boards_found = bt8[4:0];
    wr.r0.last         = !two;
    wr.r0.fault        = flt && !two;
    wr.r1 = r1;
    wr.r1.busy_res     = (mode_next != dcbms_pkg::MODE_IDLE);
    wr.r1.boards_found = bt8[4:0];
    wr.r1.last         = 1'b1;
    wr.r1.fault        = flt;
  end

  a_idle_timer_off: assert property (@(posedge clk) disable iff (rst)
    mode == dcbms_pkg::MODE_IDLE |-> !timer_on)
    else $error("Reply timer runs while the sequencer is idle.");

  a_board_limit: assert property (@(posedge clk) disable iff (rst)
    board_total <= BW'(MAX_BOARDS))
    else $error("Board count passed its limit.");

  a_poll_position: assert property (@(posedge clk) disable iff (rst)
    (mode == dcbms_pkg::MODE_VOLT || mode == dcbms_pkg::MODE_STAT) |->
      (cur_board != '0 && cur_board <= board_total && cur_cell != '0))
    else $error("Poll position lies outside the addressed chain.");

endmodule

FILE: rtl/daisy_chain_bms_poll_master.sv
// Channel  Direction  Handshake            Contents
// s_*      in         s_tvalid / s_tready  command, reply packet or timer tick
// m_*      out        m_tvalid / m_tready  request to send and store write, tlast per input
// cfg_*    in         cfg_valid / cfg_ready register index and write data
//
// Each input transaction is registered, then handled, and yields one or two results.
// While each yields one result and results are taken as they come, one input transaction is
// accepted every cycle; each result is offered from the result queue after the input is handled.
// A four-entry result queue decouples the two sides; input stalls when it cannot hold two more.
// Reset is synchronous and returns registers to defaults and the sequencer to idle.
// Configuration writes are taken in every cycle.
module daisy_chain_bms_poll_master #(
  parameter int MAX_BOARDS = dcbms_pkg::MAX_BOARDS_DEF,
  parameter int MAX_BATTS  = dcbms_pkg::MAX_BATTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // payload
  input  logic [3:0]  s_tuser,   // operation, packet_kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // dest_board, var_index, set_value, store_index,
                                 // store_value, fault, busy_res, boards_found, zero fill
  output logic [3:0]  m_tuser,   // send_kind, store_kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dcbms_pkg::oq_wr_t wr;
  dcbms_pkg::res_t   res;
  logic              room;

  assign cfg_ready = 1'b1;

  dcbms_core #(
    .MAX_BOARDS (MAX_BOARDS),
    .MAX_BATTS  (MAX_BATTS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .s_op      (s_tuser[1:0]),
    .s_pk      (s_tuser[3:2]),
    .s_pay     (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .room      (room),
    .wr        (wr)
  );

  dcbms_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .room    (room),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_data  (res)
  );

  assign m_tuser = {res.store_kind, res.req.send_kind};
  assign m_tlast = res.last;
  assign m_tdata = {1'b0, res.boards_found, res.busy_res, res.fault, res.store_value,
                    res.store_index, res.req.set_value, res.req.var_index,
                    res.req.dest_board};

endmodule

FILE: dv/tb_top.sv
module tb_top;

  localparam int NBOARDS     = dcbms_pkg::MAX_BOARDS_DEF;
  localparam int NBATTS      = dcbms_pkg::MAX_BATTS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    logic [1:0]  op;
    logic [1:0]  pk;
    logic [31:0] pay;
  } chain_cmd_t;

  typedef struct packed {
    logic [1:0]  send;
    logic [7:0]  dest;
    logic [15:0] var_idx;
    logic [7:0]  setv;
    logic [1:0]  store;
    logic [7:0]  sidx;
    logic [31:0] sval;
    logic        fault;
    logic        busy;
    logic [4:0]  boards;
    logic        last;
  } chain_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  daisy_chain_bms_poll_master uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  logic [15:0] cfg_timeout   = dcbms_pkg::TIMEOUT_RST;
  logic [3:0]  cfg_retries   = dcbms_pkg::MAX_RETRIES_RST;
  logic [15:0] cfg_reg_addr  = dcbms_pkg::REG_ADDR_RST;
  logic [15:0] cfg_reg_cells = dcbms_pkg::REG_CELLS_RST;
  logic [15:0] cfg_reg_volt  = dcbms_pkg::REG_VOLT_RST;
  logic [15:0] cfg_reg_stat  = dcbms_pkg::REG_STAT_RST;

  dcbms_pkg::mode_t seq_mode = dcbms_pkg::MODE_IDLE;
  logic [3:0]  retry_n = '0;
  logic [4:0]  board_n = '0;
  logic [4:0]  cell_cnt [NBOARDS];
  logic [4:0]  poll_board = '0;
  logic [4:0]  poll_cell = '0;
  logic [7:0]  flat_idx = '0;
  logic        timer_run = 1'b0;
  logic [15:0] tick_n = '0;
  logic [7:0]  last_dest = '0;
  logic [15:0] last_var = '0;
  logic [7:0]  last_setv = '0;

  chain_cmd_t  cmd_q [$];
  chain_res_t  due_results [$];
  chain_cmd_t  cur_cmd;
  bit          drv_busy = 1'b0;
  int          queued_n = 0;
  int          err_n = 0;
  int          res_n = 0;
  int          cycle_n = 0;
  int          sender_idle_pct = 6;
  int          recv_stall_pct = 6;

  initial begin
    for (int i = 0; i < NBOARDS; i++) cell_cnt[i] = '0;
  end

  function automatic void set_request(inout chain_res_t r, input logic [1:0] k,
                                      input logic [7:0] d, input logic [15:0] v,
                                      input logic [7:0] s);
    r.send = k;
    r.dest = d;
    r.var_idx = v;
    r.setv = s;
    last_dest = d;
    last_var = v;
    last_setv = s;
  endfunction

  function automatic void arm_timer();
    timer_run = 1'b1;
    tick_n = '0;
  endfunction

  function automatic void to_idle();
    seq_mode = dcbms_pkg::MODE_IDLE;
    timer_run = 1'b0;
    tick_n = '0;
  endfunction

  function automatic void repeat_request(inout chain_res_t r);
    r.send = dcbms_pkg::SEND_RESEND;
    r.dest = last_dest;
    r.var_idx = last_var;
    r.setv = last_setv;
    arm_timer();
  endfunction

  function automatic bit retry_or_give_up(inout chain_res_t r);
    if (retry_n >= cfg_retries) begin
      to_idle();
      return 1'b1;
    end
    retry_n++;
    repeat_request(r);
    return 1'b0;
  endfunction

  function automatic void take_reading(inout chain_res_t r, input logic [31:0] pay);
    logic [15:0] first;
    logic [7:0]  bi;
    logic [4:0]  have;
    bit          volt;
    volt = (seq_mode == dcbms_pkg::MODE_VOLT);
    first = volt ? cfg_reg_volt : cfg_reg_stat;
    r.store = volt ? dcbms_pkg::STORE_VOLT : dcbms_pkg::STORE_STAT;
    r.sidx = flat_idx;
    r.sval = pay;
    flat_idx++;
    bi = {3'd0, poll_board} - 8'd1;
    have = (bi < NBOARDS) ? cell_cnt[bi[3:0]] : 5'd0;
    if (poll_cell >= have) begin
      if (poll_board >= board_n) begin
        if (volt) begin
          poll_board = 5'd1;
          poll_cell = 5'd1;
          flat_idx = '0;
          retry_n = '0;
          seq_mode = dcbms_pkg::MODE_STAT;
          set_request(r, dcbms_pkg::SEND_GET, 8'd1, cfg_reg_stat, 8'd0);
          arm_timer();
        end else begin
          to_idle();
        end
        return;
      end
      poll_board++;
      poll_cell = 5'd1;
    end else begin
      poll_cell++;
    end
    retry_n = '0;
    set_request(r, dcbms_pkg::SEND_GET, {3'd0, poll_board},
                first + {11'd0, poll_cell} - 16'd1, 8'd0);
    arm_timer();
  endfunction

  function automatic void advance_sequencer(input logic [1:0] op, input logic [1:0] pk,
                                            input logic [31:0] pay);
    chain_res_t  r [2];
    int          n;
    bit          flt;
    logic [15:0] cnt;
    n = 1;
    flt = 1'b0;
    r[0] = '0;
    r[1] = '0;
    case (op)
      dcbms_pkg::OP_RESTART: begin
        board_n = '0;
        for (int i = 0; i < NBOARDS; i++) cell_cnt[i] = '0;
        set_request(r[0], dcbms_pkg::SEND_SET, dcbms_pkg::DEST_BROADCAST, cfg_reg_addr, 8'd0);
        set_request(r[1], dcbms_pkg::SEND_SET, 8'd0, cfg_reg_addr, 8'd1);
        retry_n = '0;
        seq_mode = dcbms_pkg::MODE_ADDR;
        arm_timer();
        n = 2;
      end
      dcbms_pkg::OP_REFRESH: begin
        if (board_n != 0) begin
          poll_board = 5'd1;
          poll_cell = 5'd1;
          flat_idx = '0;
          retry_n = '0;
          seq_mode = dcbms_pkg::MODE_VOLT;
          set_request(r[0], dcbms_pkg::SEND_GET, 8'd1, cfg_reg_volt, 8'd0);
          arm_timer();
        end
      end
      dcbms_pkg::OP_REPLY: begin
        if (seq_mode == dcbms_pkg::MODE_ADDR) begin
          if (pk == dcbms_pkg::PK_ACK) begin
            if (board_n < NBOARDS) board_n++;
            retry_n = '0;
            set_request(r[0], dcbms_pkg::SEND_GET, {3'd0, board_n}, cfg_reg_cells, 8'd0);
            arm_timer();
          end else if (pk == dcbms_pkg::PK_RESULT && board_n != 0) begin
            cnt = pay[15:0];
            if (cnt > NBATTS) cnt = 16'(NBATTS);
            cell_cnt[4'(board_n - 5'd1)] = cnt[4:0];
            if (board_n >= NBOARDS) begin
              to_idle();
            end else begin
              retry_n = '0;
              set_request(r[0], dcbms_pkg::SEND_SET, 8'd0, cfg_reg_addr,
                          {3'd0, board_n} + 8'd1);
              arm_timer();
            end
          end else begin
            flt = retry_or_give_up(r[0]);
          end
        end else if (seq_mode != dcbms_pkg::MODE_IDLE) begin
          if (pk == dcbms_pkg::PK_RESULT) take_reading(r[0], pay);
          else flt = retry_or_give_up(r[0]);
        end
      end
      default: begin
        if (timer_run) begin
          if (tick_n >= cfg_timeout) begin
            timer_run = 1'b0;
            tick_n = '0;
            if (seq_mode == dcbms_pkg::MODE_ADDR) begin
              if (retry_n >= cfg_retries) begin
                to_idle();
                flt = (board_n == 0);
              end else begin
                retry_n++;
                if (board_n == 0) begin
                  set_request(r[0], dcbms_pkg::SEND_SET, dcbms_pkg::DEST_BROADCAST,
                              cfg_reg_addr, 8'd0);
                  set_request(r[1], dcbms_pkg::SEND_SET, 8'd0, cfg_reg_addr, 8'd1);
                  arm_timer();
                  n = 2;
                end else begin
                  repeat_request(r[0]);
                end
              end
            end else if (seq_mode != dcbms_pkg::MODE_IDLE) begin
              flt = retry_or_give_up(r[0]);
            end
          end else begin
            tick_n++;
          end
        end
      end
    endcase
    for (int k = 0; k < n; k++) begin
      r[k].fault = (k == n - 1) && flt;
      r[k].busy = (seq_mode != dcbms_pkg::MODE_IDLE);
      r[k].boards = board_n;
      r[k].last = (k == n - 1);
      due_results.push_back(r[k]);
    end
  endfunction

  function automatic void apply_setting(input logic [2:0] idx, input logic [15:0] d);
    case (idx)
      dcbms_pkg::CFG_TIMEOUT:     cfg_timeout = d;
      dcbms_pkg::CFG_MAX_RETRIES: cfg_retries = d[3:0];
      dcbms_pkg::CFG_REG_ADDR:    cfg_reg_addr = d;
      dcbms_pkg::CFG_REG_CELLS:   cfg_reg_cells = d;
      dcbms_pkg::CFG_REG_VOLT:    cfg_reg_volt = d;
      dcbms_pkg::CFG_REG_STAT:    cfg_reg_stat = d;
      default: ;
    endcase
  endfunction

  task automatic report(input string msg);
    err_n++;
    $display("ERROR at cycle %0d: %s", cycle_n, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d %s is %0h, expected %0h", res_n, name, got, want));
  endtask

  always @(posedge clk) begin
    chain_res_t want;
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result %0d", res_n));
      end else begin
        want = due_results.pop_front();
        check_field("send_kind", 32'(m_tuser[1:0]), 32'(want.send));
        check_field("store_kind", 32'(m_tuser[3:2]), 32'(want.store));
        check_field("dest_board", 32'(m_tdata[7:0]), 32'(want.dest));
        check_field("var_index", 32'(m_tdata[23:8]), 32'(want.var_idx));
        check_field("set_value", 32'(m_tdata[31:24]), 32'(want.setv));
        check_field("store_index", 32'(m_tdata[39:32]), 32'(want.sidx));
        check_field("store_value", m_tdata[71:40], want.sval);
        check_field("fault", 32'(m_tdata[72]), 32'(want.fault));
        check_field("busy_res", 32'(m_tdata[73]), 32'(want.busy));
        check_field("boards_found", 32'(m_tdata[78:74]), 32'(want.boards));
        check_field("last", 32'(m_tlast), 32'(want.last));
      end
      res_n++;
    end
    if (!rst && s_tvalid && s_tready) begin
      advance_sequencer(cur_cmd.op, cur_cmd.pk, cur_cmd.pay);
      drv_busy = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      if (!drv_busy) begin
        if (cmd_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          cur_cmd = cmd_q.pop_front();
          drv_busy = 1'b1;
          s_tvalid <= 1'b1;
          s_tdata <= cur_cmd.pay;
          s_tuser <= {cur_cmd.pk, cur_cmd.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic queue_cmd(input logic [1:0] op, input logic [1:0] pk, input logic [31:0] pay);
    chain_cmd_t c;
    c.op = op;
    c.pk = pk;
    c.pay = pay;
    cmd_q.push_back(c);
    queued_n++;
  endtask

  task automatic maybe_noise(input bit polling);
    int pick;
    if ($urandom_range(99, 0) < 4) begin
      pick = $urandom_range(3, 0);
      if (pick == 0) queue_cmd(dcbms_pkg::OP_TICK, 2'($urandom), $urandom);
      else if (pick == 1 && polling) queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_ACK, $urandom);
      else queue_cmd(dcbms_pkg::OP_REPLY, 2'($urandom_range(3, 2)), $urandom);
    end
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_cmd(dcbms_pkg::OP_TICK, 2'($urandom), $urandom);
  endtask

  task automatic queue_chain_session();
    int          sel;
    int          nb;
    int          total;
    int          eff;
    int          timeout_len;
    bit          cheap;
    logic [31:0] pay;
    timeout_len = (int'(cfg_retries) + 1) * (int'(cfg_timeout) + 1);
    cheap = (timeout_len <= 120);
    sel = $urandom_range(99, 0);
    if (sel < 10) begin
      repeat ($urandom_range(10, 3))
        queue_cmd(2'($urandom), 2'($urandom), $urandom);
      return;
    end
    if (sel < 18 && cheap) begin
      queue_cmd(dcbms_pkg::OP_RESTART, 2'($urandom), $urandom);
      queue_ticks(timeout_len + $urandom_range(2, 0));
      return;
    end
    nb = ($urandom_range(9, 0) == 0) ? NBOARDS : $urandom_range(5, 1);
    queue_cmd(dcbms_pkg::OP_RESTART, 2'($urandom), $urandom);
    total = 0;
    for (int b = 1; b <= nb; b++) begin
      maybe_noise(1'b0);
      queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_ACK, $urandom);
      if (b == NBOARDS && $urandom_range(1, 0) == 1)
        queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_ACK, $urandom);
      maybe_noise(1'b0);
      sel = $urandom_range(99, 0);
      if (nb == NBOARDS) pay = {16'($urandom), 16'($urandom_range(2, 0))};
      else if (sel < 70) pay = {16'($urandom), 16'($urandom_range(4, 0))};
      else if (sel < 85) pay = {16'($urandom), 16'($urandom_range(20, 16))};
      else pay = $urandom;
      queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_RESULT, pay);
      eff = (pay[15:0] > NBATTS) ? NBATTS : int'(pay[15:0]);
      total += (eff == 0) ? 1 : eff;
    end
    if (nb < NBOARDS && cheap && $urandom_range(1, 0) == 1) queue_ticks(timeout_len);
    queue_cmd(dcbms_pkg::OP_REFRESH, 2'($urandom), $urandom);
    for (int k = 0; k < 2 * total; k++) begin
      maybe_noise(1'b1);
      if ($urandom_range(199, 0) == 0) return;
      queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_RESULT, $urandom);
    end
  endtask

  task automatic write_setting(input logic [2:0] idx, input logic [15:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_setting(idx, d);
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || drv_busy || due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [15:0] t;
    logic [15:0] rr;
    logic [15:0] regs [4];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Replies and ticks while idle, refresh with no boards, a result before any
    // acknowledge, a board with no cells, a refresh taking over addressing.
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_ACK, 32'h0);
    queue_cmd(dcbms_pkg::OP_REPLY, 2'd3, 32'hFFFF_FFFF);
    queue_cmd(dcbms_pkg::OP_TICK, dcbms_pkg::PK_ACK, 32'h0);
    queue_cmd(dcbms_pkg::OP_REFRESH, dcbms_pkg::PK_RESULT, 32'hFFFF_FFFF);
    queue_cmd(dcbms_pkg::OP_RESTART, dcbms_pkg::PK_ACK, 32'h0);
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_RESULT, 32'h0000_0003);
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_OTHER, 32'h0);
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_ACK, 32'h0);
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_RESULT, 32'hFFFF_0000);
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_ACK, 32'hFFFF_FFFF);
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_RESULT, 32'h0000_0002);
    queue_cmd(dcbms_pkg::OP_REFRESH, 2'd3, 32'h0);
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_RESULT, 32'hFFFF_FFFF);
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_OTHER, 32'h1234_5678);
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_RESULT, 32'h0000_0000);
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_RESULT, 32'h8000_0001);
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_RESULT, 32'h7FFF_FFFF);
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_RESULT, 32'h0001_0000);
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_RESULT, 32'hFFFF_FFFF);
    queue_cmd(dcbms_pkg::OP_TICK, 2'd3, 32'hFFFF_FFFF);
    queue_cmd(dcbms_pkg::OP_REFRESH, dcbms_pkg::PK_ACK, 32'h0);
    queue_cmd(dcbms_pkg::OP_REPLY, dcbms_pkg::PK_RESULT, 32'hA5A5_5A5A);
    queue_cmd(dcbms_pkg::OP_RESTART, 2'd3, 32'hFFFF_FFFF);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          t = 16'd1;
          rr = 16'd0;
          for (int i = 0; i < 4; i++) regs[i] = 16'h0000;
        end
        1: begin
          t = 16'hFFFF;
          rr = 16'd15;
          for (int i = 0; i < 4; i++) regs[i] = 16'hFFFF;
        end
        default: begin
          t = 16'($urandom_range(6, 1));
          rr = 16'($urandom_range(5, 0));
          for (int i = 0; i < 4; i++) regs[i] = 16'($urandom);
        end
      endcase
      if (ph == 7) rr = {12'($urandom), 4'd15};
      write_setting(dcbms_pkg::CFG_TIMEOUT, t);
      write_setting(dcbms_pkg::CFG_MAX_RETRIES, rr);
      write_setting(dcbms_pkg::CFG_REG_ADDR, regs[0]);
      write_setting(dcbms_pkg::CFG_REG_CELLS, regs[1]);
      write_setting(dcbms_pkg::CFG_REG_VOLT, regs[2]);
      write_setting(dcbms_pkg::CFG_REG_STAT, regs[3]);
      @(negedge clk);
      cfg_valid <= 1'b0;
      sender_idle_pct = (ph == 2) ? 0 : 6;
      recv_stall_pct = (ph == 2) ? 0 : 6;
      queued_n = 0;
      while (queued_n < PHASE_ITEMS) queue_chain_session();
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (err_n == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
